### hw/rtl/pdic_pkg.sv
package pdic_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 32;

	// round(0.0012 * 2^32) and round(0.0001 * 2^FRAC_BITS), ties up
	localparam logic [63:0] RANGE_GAIN_W = (64'd12 * 64'd4294967296 + 64'd5000) / 64'd10000;
	localparam logic [22:0] RANGE_GAIN   = RANGE_GAIN_W[22:0];
	localparam logic [63:0] OFFSET_W     = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam logic signed [33:0] OFFSET_QF = $signed(OFFSET_W[33:0]);
	localparam logic signed [33:0] DIST_MAX  = 34'sh0_7FFF_FFFF;

	typedef enum logic [2:0] {
		CFG_PLANE_A   = 3'd0,
		CFG_PLANE_B   = 3'd1,
		CFG_PLANE_C   = 3'd2,
		CFG_PLANE_D   = 3'd3,
		CFG_THRESHOLD = 3'd4,
		CFG_FILTER_EN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [31:0] thr;
		logic               fe;
	} cfg_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} point_t;

	typedef struct packed {
		point_t pt;
		logic   deg;
	} side_t;

endpackage

### hw/rtl/plane_distance_inlier_classifier.sv
// Pipeline: product/sum, square root, divide, then range term and saturate; a skid slot holds
// one result while the consumer stalls. Throughput: one point per cycle while the slot is empty;
// the 32-step root and divide are fully pipelined, one bit a stage.
// Reset: arst_n clears all valid bits and the skid slot and loads the plane registers with
// a=0, b=0, c=1.0, d=0, threshold 6554, filter enabled.
module plane_distance_inlier_classifier import pdic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] plane_distance,
	output logic        keep,
	output logic        degenerate_plane
);

	cfg_t cfg_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a   <= 32'sd0;
			cfg_q.b   <= 32'sd0;
			cfg_q.c   <= 32'sd65536;
			cfg_q.d   <= 32'sd0;
			cfg_q.thr <= 32'sd6554;
			cfg_q.fe  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PLANE_A:   cfg_q.a   <= cfg_data;
				CFG_PLANE_B:   cfg_q.b   <= cfg_data;
				CFG_PLANE_C:   cfg_q.c   <= cfg_data;
				CFG_PLANE_D:   cfg_q.d   <= cfg_data;
				CFG_THRESHOLD: cfg_q.thr <= cfg_data;
				CFG_FILTER_EN: cfg_q.fe  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	point_t      in_pt;
	logic        f_vld, r_vld, d_vld, p_vld;
	side_t       f_side, r_side, d_side;
	logic [63:0] f_num, f_nsq, f_rsq, r_num;
	logic [31:0] r_norm, r_range, d_quo, d_range;
	logic        d_ovf;
	point_t      p_pt;
	logic [31:0] p_dist;
	logic        p_keep, p_deg;

	assign in_pt = '{x: point_x, y: point_y, z: point_z};

	pdic_front u_front (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.in_vld(in_valid && in_ready), .in_pt,
		.out_vld(f_vld), .out_side(f_side),
		.out_num(f_num), .out_nsq(f_nsq), .out_rsq(f_rsq)
	);

	pdic_root u_root (
		.clk, .arst_n, .en,
		.in_vld(f_vld), .in_side(f_side), .in_num(f_num), .in_nsq(f_nsq), .in_rsq(f_rsq),
		.out_vld(r_vld), .out_side(r_side), .out_num(r_num),
		.out_norm(r_norm), .out_range(r_range)
	);

	pdic_div u_div (
		.clk, .arst_n, .en,
		.in_vld(r_vld), .in_side(r_side), .in_num(r_num), .in_norm(r_norm),
		.in_range(r_range),
		.out_vld(d_vld), .out_side(d_side), .out_quo(d_quo), .out_ovf(d_ovf),
		.out_range(d_range)
	);

	pdic_post u_post (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.in_vld(d_vld), .in_side(d_side), .in_quo(d_quo), .in_ovf(d_ovf),
		.in_range(d_range),
		.out_vld(p_vld), .out_pt(p_pt), .out_dist(p_dist),
		.out_keep(p_keep), .out_deg(p_deg)
	);

	// skid slot: catches the last stage when the consumer stalls
	logic        skid_full_q;
	point_t      skid_pt_q;
	logic [31:0] skid_dist_q;
	logic        skid_keep_q, skid_deg_q;

	assign en       = !skid_full_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (p_vld && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && p_vld && !out_ready) begin
			skid_pt_q   <= p_pt;
			skid_dist_q <= p_dist;
			skid_keep_q <= p_keep;
			skid_deg_q  <= p_deg;
		end
	end

	assign out_valid        = skid_full_q || p_vld;
	assign out_x            = skid_full_q ? skid_pt_q.x : p_pt.x;
	assign out_y            = skid_full_q ? skid_pt_q.y : p_pt.y;
	assign out_z            = skid_full_q ? skid_pt_q.z : p_pt.z;
	assign plane_distance   = skid_full_q ? skid_dist_q : p_dist;
	assign keep             = skid_full_q ? skid_keep_q : p_keep;
	assign degenerate_plane = skid_full_q ? skid_deg_q : p_deg;

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !out_ready |=> skid_full_q && $stable(skid_dist_q) && $stable(skid_pt_q))
		else $error("skid slot lost or changed a stalled result");

	a_deg_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate_plane |-> !keep && plane_distance == 32'd0)
		else $error("degenerate plane result kept or nonzero");

	a_nofilter_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate_plane && !cfg_q.fe |-> keep)
		else $error("point dropped with filtering off");

	a_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep && cfg_q.fe |-> $signed(plane_distance) <= cfg_q.thr)
		else $error("kept point beyond threshold");

endmodule

### hw/rtl/pdic_front.sv
module pdic_front import pdic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic        in_vld,
	input  point_t      in_pt,
	output logic        out_vld,
	output side_t       out_side,
	output logic [63:0] out_num,
	output logic [63:0] out_nsq,
	output logic [63:0] out_rsq
);

	function automatic logic [31:0] mag(logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic signed [66:0] sterm(logic [63:0] m, logic neg);
		logic signed [66:0] t;
		t = $signed({3'b000, m});
		return neg ? -t : t;
	endfunction

	logic        vld_s1, vld_s2;
	point_t      pt_s1;
	logic        deg_s1;
	logic [63:0] pax_s1, pby_s1, pcz_s1;
	logic        sax_s1, sby_s1, scz_s1;
	logic [63:0] aa_s1, bb_s1, cc_s1, xx_s1, yy_s1, zz_s1;
	side_t       side_s2;
	logic [63:0] num_s2, nsq_s2, rsq_s2;

	logic [31:0] ma, mb, mc, mx, my, mz;
	logic signed [66:0] lin;
	logic [63:0] dmag;
	logic [65:0] nsq_w, rsq_w;

	assign ma = mag(cfg.a);
	assign mb = mag(cfg.b);
	assign mc = mag(cfg.c);
	assign mx = mag(in_pt.x);
	assign my = mag(in_pt.y);
	assign mz = mag(in_pt.z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1  <= in_pt;
			deg_s1 <= (cfg.a == 32'sd0) && (cfg.b == 32'sd0) && (cfg.c == 32'sd0);
			pax_s1 <= 64'(ma) * 64'(mx);
			pby_s1 <= 64'(mb) * 64'(my);
			pcz_s1 <= 64'(mc) * 64'(mz);
			sax_s1 <= cfg.a[31] ^ in_pt.x[31];
			sby_s1 <= cfg.b[31] ^ in_pt.y[31];
			scz_s1 <= cfg.c[31] ^ in_pt.z[31];
			aa_s1  <= 64'(ma) * 64'(ma);
			bb_s1  <= 64'(mb) * 64'(mb);
			cc_s1  <= 64'(mc) * 64'(mc);
			xx_s1  <= 64'(mx) * 64'(mx);
			yy_s1  <= 64'(my) * 64'(my);
			zz_s1  <= 64'(mz) * 64'(mz);
		end
	end

	assign dmag  = 64'(mag(cfg.d)) << FRAC_BITS;
	assign lin   = sterm(pax_s1, sax_s1) + sterm(pby_s1, sby_s1) + sterm(pcz_s1, scz_s1)
	             + sterm(dmag, cfg.d[31]);
	assign nsq_w = 66'(aa_s1) + 66'(bb_s1) + 66'(cc_s1);
	assign rsq_w = 66'(xx_s1) + 66'(yy_s1) + 66'(zz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.pt  <= pt_s1;
			side_s2.deg <= deg_s1;
			num_s2      <= lin[66] ? 64'(-lin) : lin[63:0];
			nsq_s2      <= nsq_w[63:0];
			rsq_s2      <= rsq_w[63:0];
		end
	end

	assign out_vld  = vld_s2;
	assign out_side = side_s2;
	assign out_num  = num_s2;
	assign out_nsq  = nsq_s2;
	assign out_rsq  = rsq_s2;

endmodule

### hw/rtl/pdic_root.sv
module pdic_root import pdic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [63:0] in_num,
	input  logic [63:0] in_nsq,
	input  logic [63:0] in_rsq,
	output logic        out_vld,
	output side_t       out_side,
	output logic [63:0] out_num,
	output logic [31:0] out_norm,
	output logic [31:0] out_range
);

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} root_t;

	function automatic root_t step(logic [33:0] rem, logic [31:0] root, logic [1:0] bits);
		logic [35:0] acc;
		logic [35:0] trial;
		root_t r;
		acc   = {rem, bits};
		trial = {2'b00, root, 2'b01};
		if (acc >= trial) begin
			r.rem  = 34'(acc - trial);
			r.root = {root[30:0], 1'b1};
		end else begin
			r.rem  = acc[33:0];
			r.root = {root[30:0], 1'b0};
		end
		return r;
	endfunction

	logic        vld_s   [0:ROOT_STEPS];
	side_t       side_s  [0:ROOT_STEPS];
	logic [63:0] num_s   [0:ROOT_STEPS];
	logic [63:0] nrad_s  [0:ROOT_STEPS];
	logic [63:0] rrad_s  [0:ROOT_STEPS];
	logic [33:0] nrem_s  [0:ROOT_STEPS];
	logic [33:0] rrem_s  [0:ROOT_STEPS];
	logic [31:0] nroot_s [0:ROOT_STEPS];
	logic [31:0] rroot_s [0:ROOT_STEPS];

	assign vld_s[0]   = in_vld;
	assign side_s[0]  = in_side;
	assign num_s[0]   = in_num;
	assign nrad_s[0]  = in_nsq;
	assign rrad_s[0]  = in_rsq;
	assign nrem_s[0]  = '0;
	assign rrem_s[0]  = '0;
	assign nroot_s[0] = '0;
	assign rroot_s[0] = '0;

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		root_t nr, rr;
		assign nr = step(nrem_s[k], nroot_s[k], nrad_s[k][63:62]);
		assign rr = step(rrem_s[k], rroot_s[k], rrad_s[k][63:62]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1]  <= side_s[k];
				num_s[k+1]   <= num_s[k];
				nrad_s[k+1]  <= {nrad_s[k][61:0], 2'b00};
				rrad_s[k+1]  <= {rrad_s[k][61:0], 2'b00};
				nrem_s[k+1]  <= nr.rem;
				rrem_s[k+1]  <= rr.rem;
				nroot_s[k+1] <= nr.root;
				rroot_s[k+1] <= rr.root;
			end
		end
	end

	assign out_vld   = vld_s[ROOT_STEPS];
	assign out_side  = side_s[ROOT_STEPS];
	assign out_num   = num_s[ROOT_STEPS];
	assign out_norm  = nroot_s[ROOT_STEPS];
	assign out_range = rroot_s[ROOT_STEPS];

endmodule

### hw/rtl/pdic_div.sv
module pdic_div import pdic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [63:0] in_num,
	input  logic [31:0] in_norm,
	input  logic [31:0] in_range,
	output logic        out_vld,
	output side_t       out_side,
	output logic [31:0] out_quo,
	output logic        out_ovf,
	output logic [31:0] out_range
);

	logic        vld_s   [0:DIV_STEPS];
	side_t       side_s  [0:DIV_STEPS];
	logic        ovf_s   [0:DIV_STEPS];
	logic [31:0] range_s [0:DIV_STEPS];
	logic [31:0] norm_s  [0:DIV_STEPS];
	logic [31:0] rem_s   [0:DIV_STEPS];
	logic [31:0] low_s   [0:DIV_STEPS];
	logic [31:0] quo_s   [0:DIV_STEPS];

	logic [63:0] rnum;
	assign rnum = in_num + {33'd0, in_norm[31:1]};

	// rounded dividend; quotient needs more than 32 bits when its top half reaches the norm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0]  <= in_side;
			ovf_s[0]   <= rnum[63:32] >= in_norm;
			range_s[0] <= in_range;
			norm_s[0]  <= in_norm;
			rem_s[0]   <= rnum[63:32];
			low_s[0]   <= rnum[31:0];
			quo_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [32:0] acc;
		logic        take;
		assign acc  = {rem_s[k], low_s[k][31]};
		assign take = acc >= {1'b0, norm_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1]  <= side_s[k];
				ovf_s[k+1]   <= ovf_s[k];
				range_s[k+1] <= range_s[k];
				norm_s[k+1]  <= norm_s[k];
				rem_s[k+1]   <= take ? 32'(acc - {1'b0, norm_s[k]}) : acc[31:0];
				low_s[k+1]   <= {low_s[k][30:0], 1'b0};
				quo_s[k+1]   <= {quo_s[k][30:0], take};
			end
		end
	end

	assign out_vld   = vld_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];
	assign out_quo   = quo_s[DIV_STEPS];
	assign out_ovf   = ovf_s[DIV_STEPS];
	assign out_range = range_s[DIV_STEPS];

endmodule

### hw/rtl/pdic_post.sv
module pdic_post import pdic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic        in_vld,
	input  side_t       in_side,
	input  logic [31:0] in_quo,
	input  logic        in_ovf,
	input  logic [31:0] in_range,
	output logic        out_vld,
	output point_t      out_pt,
	output logic [31:0] out_dist,
	output logic        out_keep,
	output logic        out_deg
);

	logic        vld_s1, vld_s2;
	side_t       side_s1;
	logic [31:0] quo_s1;
	logic        ovf_s1;
	logic [54:0] prod_s1;
	point_t      pt_s2;
	logic [31:0] dist_s2;
	logic        keep_s2, deg_s2;

	logic [55:0]        rnd;
	logic signed [33:0] total;
	logic [31:0]        dist_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			quo_s1  <= in_quo;
			ovf_s1  <= in_ovf;
			prod_s1 <= 55'(in_range) * 55'(RANGE_GAIN);
		end
	end

	assign rnd   = 56'(prod_s1) + 56'h0_0000_8000_0000;
	assign total = $signed({2'b00, quo_s1}) + $signed({10'd0, rnd[55:32]}) - OFFSET_QF;

	always_comb begin
		if (side_s1.deg) begin
			dist_w = '0;
		end else if (ovf_s1 || total > DIST_MAX) begin
			dist_w = DIST_MAX[31:0];
		end else begin
			dist_w = total[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2   <= side_s1.pt;
			dist_s2 <= dist_w;
			deg_s2  <= side_s1.deg;
			keep_s2 <= !side_s1.deg && (!cfg.fe || ($signed(dist_w) <= cfg.thr));
		end
	end

	assign out_vld  = vld_s2;
	assign out_pt   = pt_s2;
	assign out_dist = dist_s2;
	assign out_keep = keep_s2;
	assign out_deg  = deg_s2;

endmodule

### tb/sv/plane_distance_inlier_classifier_tb.sv
module plane_distance_inlier_classifier_tb import pdic_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 80;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] pdist;
		logic        keep;
		logic        deg;
	} classified_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [31:0] plane_distance;
	logic        keep;
	logic        degenerate_plane;

	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_hold = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	class plane_scoreboard;
		logic signed [31:0] a, b, c, d, thr;
		logic fe;
		classified_t pending[$];

		function new();
			a = 0; b = 0; c = ONE_Q; d = 0; thr = 32'sd6554; fe = 1'b1;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				CFG_PLANE_A: a = v;
				CFG_PLANE_B: b = v;
				CFG_PLANE_C: c = v;
				CFG_PLANE_D: d = v;
				CFG_THRESHOLD: thr = v;
				CFG_FILTER_EN: fe = v[0];
				default: ;
			endcase
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r, bt;
			r = 0;
			bt = 64'd1 << 62;
			while (bt > v) bt = bt >> 2;
			while (bt != 0) begin
				if (v >= r + bt) begin
					v = v - (r + bt);
					r = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
			return r;
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
			classified_t e;
			longint sx, sy, sz, sa, sb, sc, sd, t, total;
			longint unsigned nsq, pos, neg, num, norm, q, rng, rterm;
			sx = longint'($signed(px)); sy = longint'($signed(py)); sz = longint'($signed(pz));
			sa = a; sb = b; sc = c; sd = d;
			e.x = px; e.y = py; e.z = pz; e.pdist = 0; e.keep = 0; e.deg = 0;
			nsq = mag(sa) * mag(sa) + mag(sb) * mag(sb) + mag(sc) * mag(sc);
			if (nsq == 0) begin
				e.deg = 1;
			end else begin
				pos = 0; neg = 0;
				t = sa * sx; if (t < 0) neg += mag(t); else pos += t;
				t = sb * sy; if (t < 0) neg += mag(t); else pos += t;
				t = sc * sz; if (t < 0) neg += mag(t); else pos += t;
				if (sd < 0) neg += mag(sd) << FRAC_BITS; else pos += mag(sd) << FRAC_BITS;
				num = pos >= neg ? pos - neg : neg - pos;
				norm = root_floor(nsq);
				q = (num + (norm >> 1)) / norm;
				if (q > (64'd1 << 40)) q = 64'd1 << 40;
				rng = root_floor(mag(sx) * mag(sx) + mag(sy) * mag(sy) + mag(sz) * mag(sz));
				rterm = (rng * RANGE_GAIN_W + 64'h8000_0000) >> 32;
				total = longint'(q) + longint'(rterm) - longint'(OFFSET_W);
				if (total > 64'sd2147483647) total = 64'sd2147483647;
				if (total < -64'sd2147483648) total = -64'sd2147483648;
				e.pdist = total[31:0];
				e.keep = fe ? (total <= longint'(thr)) : 1'b1;
			end
			pending = {pending, e};
		endfunction

		task check_result(classified_t r);
			classified_t e;
			if (pending.size() == 0) begin
				report("unexpected transfer, x", r.x, 0);
				return;
			end
			e = pending.pop_front();
			if (r.x !== e.x) report("out_x", r.x, e.x);
			if (r.y !== e.y) report("out_y", r.y, e.y);
			if (r.z !== e.z) report("out_z", r.z, e.z);
			if (r.pdist !== e.pdist) report("plane_distance", r.pdist, e.pdist);
			if (r.keep !== e.keep) report("keep", 32'(r.keep), 32'(e.keep));
			if (r.deg !== e.deg) report("degenerate_plane", 32'(r.deg), 32'(e.deg));
		endtask
	endclass

	plane_scoreboard sb = new();

	plane_distance_inlier_classifier dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** plane_distance_inlier_classifier: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		classified_t r;
		if (arst_n && in_valid && in_ready) sb.note_point(point_x, point_y, point_z);
		if (arst_n && out_valid && out_ready) begin
			r.x = out_x; r.y = out_y; r.z = out_z;
			r.pdist = plane_distance; r.keep = keep; r.deg = degenerate_plane;
			sb.check_result(r);
		end
	end

	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				stall_hold--;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_plane(input logic [31:0] pa, input logic [31:0] pb, input logic [31:0] pc,
			input logic [31:0] pd, input logic [31:0] th, input logic en);
		cfg_write(CFG_PLANE_A, pa);
		cfg_write(CFG_PLANE_B, pb);
		cfg_write(CFG_PLANE_C, pc);
		cfg_write(CFG_PLANE_D, pd);
		cfg_write(CFG_THRESHOLD, th);
		cfg_write(CFG_FILTER_EN, {31'($urandom), en});
	endtask

	// caller stands at a falling edge
	task automatic send_point(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; point_x <= px; point_y <= py; point_z <= pz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return $urandom;
			1: return S32_MIN;
			2: return S32_MAX;
			3, 4: return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
			default: return 32'($signed($urandom_range(8_000_000)) - 4_000_000);
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 0;
			default: return 32'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	task automatic random_points(input int n);
		repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 65; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 65; end
			default: begin send_idle_pct = 12; recv_stall_pct = 12; end
		endcase
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = CFG_PLANE_A; cfg_data = 0;
		in_valid = 0; point_x = 0; point_y = 0; point_z = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, reset plane z = 0, threshold 0.1
		send_point(0, 0, 0);
		send_point(0, 0, 32'sd6000);
		send_point(0, 0, 32'sd6554);
		send_point(S32_MAX, S32_MAX, S32_MAX);
		send_point(S32_MIN, S32_MIN, S32_MIN);
		send_point(S32_MIN, 0, S32_MAX);
		send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		drain();
		set_plane(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MAX, 1);
		send_point(S32_MIN, S32_MIN, S32_MIN);
		send_point(S32_MAX, S32_MAX, S32_MAX);
		send_point(0, 0, 0);
		drain();
		set_plane(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MIN, 1);
		send_point(S32_MIN, S32_MAX, 0);
		send_point(0, 0, 0);
		drain();
		set_plane(0, 0, 0, ONE_Q, S32_MAX, 0);
		send_point(ONE_Q, ONE_Q, ONE_Q);
		send_point(S32_MIN, S32_MAX, S32_MIN);
		drain();
		set_plane(0, ONE_Q, 0, -ONE_Q, 0, 0);
		send_point(0, ONE_Q, 0);
		send_point(S32_MAX, S32_MIN, S32_MAX);
		drain();
		cfg_write(CFG_SPARE_LO, $urandom);
		cfg_write(CFG_SPARE_HI, $urandom);
		set_plane(0, ONE_Q, 0, 0, 0, 1);
		send_point(0, 0, 0);
		send_point(32'sd100, 0, 0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			set_idling(ph);
			if (ph == 6) begin
				set_plane(0, 0, 0, $urandom, $urandom, 1'($urandom));
			end else begin
				set_plane(rand_coef(), rand_coef(), rand_coef() | 32'sd1,
					32'($signed($urandom_range(400000)) - 200000),
					($urandom_range(3) == 0) ? $urandom : $urandom_range(300000),
					$urandom_range(3) != 0);
			end
			if (ph == 5) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				stall_hold = 400;
			end
			// the long stall needs more points than the pipeline holds
			random_points((ph == 5) ? 120 : 55);
			drain();
		end

		if (sb.pending.size() != 0) report("results left over, count", sb.pending.size(), 0);
		if (mismatches == 0)
			$display("** plane_distance_inlier_classifier: PASSED **");
		else
			$display("** plane_distance_inlier_classifier: FAILED **");
		$finish;
	end
endmodule
